// ===== hw/rtl/depth_of_field_calculator_unit_macros.svh =====
// Assertion helpers for the depth-of-field calculator sequencer (dof_seq).
`ifndef DEPTH_OF_FIELD_CALCULATOR_UNIT_MACROS_SVH
`define DEPTH_OF_FIELD_CALCULATOR_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DOF_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define DOF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/dof_pkg.sv =====
package dof_pkg;

    // Field widths of the request and result items.
    localparam int AP_W      = 16;
    localparam int FL_W      = 20;
    localparam int FD_W      = 16;
    localparam int COC_W     = 10;
    localparam int HYP_OUT_W = 32;
    localparam int NEAR_W    = 17;
    localparam int FAR_OUT_W = 32;
    localparam int DEPTH_W   = 32;
    localparam int SUBJ_W    = 31;

    // Configuration port.
    localparam int APB_AW      = 3;
    localparam int APB_DW      = 32;
    localparam int REG_IDX_BIT = 2;
    localparam logic REG_IDX_COC  = 1'b0;
    localparam logic REG_IDX_MODE = 1'b1;
    localparam logic [COC_W-1:0] COC_RESET = 10'd5;

    // Distances at or above this value are treated as infinite.
    localparam int DIST_INF = 65500;

    // Internal value widths.
    localparam int CC_W    = 14;            // 10 * coc_size
    localparam int SQ_W    = 2 * FL_W;      // focal length squared
    localparam int DEN_W   = CC_W + AP_W;   // hyperfocal divisor
    localparam int HYP_W   = 38;            // signed, holds -1 as well
    localparam int M_W     = HYP_W - 1 + FD_W;
    localparam int FAR_W   = M_W + 1;       // signed far limit

    // Shared multiply/divide unit.
    localparam int ARITH_W = 64;
    localparam int CNT_W   = 6;

    typedef enum logic {
        OP_MUL,
        OP_DIV
    } t_op;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SQ,
        S_DMIN,
        S_HMIN,
        S_GUARD,
        S_MSUB,
        S_DSUB,
        S_DEN,
        S_HYP,
        S_CHK,
        S_MM,
        S_DNEAR,
        S_DFAR,
        S_FIN
    } t_state;

    typedef struct packed {
        logic               start;
        t_op                op;
        logic [ARITH_W-1:0] a;
        logic [ARITH_W-1:0] b;
        logic [CNT_W-1:0]   steps;
    } t_arith_req;

    typedef struct packed {
        logic               busy;
        logic               done;
        logic [ARITH_W-1:0] result;
    } t_arith_rsp;

    typedef struct packed {
        logic [COC_W-1:0] coc_size;
        logic             subject_is_near_limit;
    } t_cfg;

endpackage

// ===== hw/rtl/dof_stream_if.sv =====
// Request channel: one item per calculation.
interface dof_req_if;
    logic                      valid;
    logic                      ready;
    logic [dof_pkg::AP_W-1:0]  aperture;
    logic [dof_pkg::AP_W-1:0]  min_aperture;
    logic [dof_pkg::FL_W-1:0]  focal_length;
    logic [dof_pkg::FD_W-1:0]  focus_distance;

    modport source (
        output valid, aperture, min_aperture, focal_length, focus_distance,
        input  ready
    );
    modport sink (
        input  valid, aperture, min_aperture, focal_length, focus_distance,
        output ready
    );
endinterface

// Result channel: one item per request.
interface dof_res_if;
    logic                             valid;
    logic                             ready;
    logic signed [dof_pkg::HYP_OUT_W-1:0] hyperfocal;
    logic signed [dof_pkg::NEAR_W-1:0]    near_limit;
    logic signed [dof_pkg::FAR_OUT_W-1:0] far_limit;
    logic signed [dof_pkg::DEPTH_W-1:0]   depth;
    logic [dof_pkg::SUBJ_W-1:0]           subject_out;

    modport source (
        output valid, hyperfocal, near_limit, far_limit, depth, subject_out,
        input  ready
    );
    modport sink (
        input  valid, hyperfocal, near_limit, far_limit, depth, subject_out,
        output ready
    );
endinterface

// ===== hw/rtl/dof_regs.sv =====
module dof_regs (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [dof_pkg::APB_AW-1:0]  paddr,
    input  logic [dof_pkg::APB_DW-1:0]  pwdata,
    output logic [dof_pkg::APB_DW-1:0]  prdata,
    output logic                        pready,
    output dof_pkg::t_cfg               o_cfg
);

    logic [dof_pkg::COC_W-1:0] r_coc;
    logic                      r_mode;
    logic                      w_wr;

    // Writes complete in the access phase; the port never stalls.
    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coc  <= dof_pkg::COC_RESET;
            r_mode <= 1'b0;
        end else if (w_wr) begin
            case (paddr[dof_pkg::REG_IDX_BIT])
                dof_pkg::REG_IDX_COC:  r_coc  <= pwdata[dof_pkg::COC_W-1:0];
                dof_pkg::REG_IDX_MODE: r_mode <= pwdata[0];
                default: ;
            endcase
        end
    end

    // Read data follows the address directly.
    always_comb begin
        case (paddr[dof_pkg::REG_IDX_BIT])
            dof_pkg::REG_IDX_COC:  prdata = dof_pkg::APB_DW'(r_coc);
            dof_pkg::REG_IDX_MODE: prdata = dof_pkg::APB_DW'(r_mode);
            default:               prdata = '0;
        endcase
    end

    assign o_cfg.coc_size              = r_coc;
    assign o_cfg.subject_is_near_limit = r_mode;

endmodule

// ===== hw/rtl/dof_arith.sv =====
module dof_arith (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  dof_pkg::t_arith_req i_req,
    output dof_pkg::t_arith_rsp o_rsp
);

    localparam int W = dof_pkg::ARITH_W;

    logic                      r_busy, n_busy;
    logic                      r_done, n_done;
    dof_pkg::t_op              r_op, n_op;
    logic [dof_pkg::CNT_W-1:0] r_cnt, n_cnt;
    logic [W-1:0]              r_acc, n_acc;
    logic [W-1:0]              r_x, n_x;
    logic [W-1:0]              r_y, n_y;

    logic         w_sub;
    logic [W-1:0] w_p;
    logic [W-1:0] w_q;
    logic [W:0]   w_sum;

    // One adder serves both operations: accumulate for multiply,
    // trial subtract of the divisor for divide.
    assign w_sub = (r_op == dof_pkg::OP_DIV);
    assign w_p   = w_sub ? {r_acc[W-2:0], r_x[W-1]} : r_acc;
    assign w_q   = w_sub ? ~r_y : r_x;
    assign w_sum = {1'b0, w_p} + {1'b0, w_q} + {{W{1'b0}}, w_sub};

    // One multiplier bit or one quotient bit per cycle.
    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_op   = r_op;
        n_cnt  = r_cnt;
        n_acc  = r_acc;
        n_x    = r_x;
        n_y    = r_y;
        if (i_req.start) begin
            n_busy = 1'b1;
            n_op   = i_req.op;
            n_cnt  = i_req.steps;
            n_acc  = '0;
            n_x    = i_req.a;
            n_y    = i_req.b;
        end else if (r_busy) begin
            if (w_sub) begin
                n_acc = w_sum[W] ? w_sum[W-1:0] : w_p;
                n_x   = {r_x[W-2:0], w_sum[W]};
            end else begin
                if (r_y[0]) begin
                    n_acc = w_sum[W-1:0];
                end
                n_x = {r_x[W-2:0], 1'b0};
                n_y = {1'b0, r_y[W-1:1]};
            end
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == dof_pkg::CNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_op  <= n_op;
        r_cnt <= n_cnt;
        r_acc <= n_acc;
        r_x   <= n_x;
        r_y   <= n_y;
    end

    // Product sits in the accumulator, quotient in the dividend shifter.
    assign o_rsp.busy   = r_busy;
    assign o_rsp.done   = r_done;
    assign o_rsp.result = (r_op == dof_pkg::OP_MUL) ? r_acc : r_x;

endmodule

// ===== hw/rtl/dof_seq.sv =====
`include "depth_of_field_calculator_unit_macros.svh"

module dof_seq (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  dof_pkg::t_cfg       i_cfg,
    dof_req_if.sink             i_req,
    dof_res_if.source           o_res,
    output dof_pkg::t_arith_req o_areq,
    input  dof_pkg::t_arith_rsp i_arsp
);

    localparam int W      = dof_pkg::ARITH_W;
    localparam int HYP_W  = dof_pkg::HYP_W;
    localparam int FAR_W  = dof_pkg::FAR_W;
    localparam int M_W    = dof_pkg::M_W;
    localparam int SQ_W   = dof_pkg::SQ_W;
    localparam int DEN_W  = dof_pkg::DEN_W;
    localparam int FD_W   = dof_pkg::FD_W;
    localparam int SUBJ_W = dof_pkg::SUBJ_W;
    localparam int NEAR_W = dof_pkg::NEAR_W;
    localparam int OUT_W  = dof_pkg::HYP_OUT_W;

    dof_pkg::t_state r_state, n_state;
    logic            r_launched, n_launched;

    logic                        r_mode, n_mode;
    logic [dof_pkg::CC_W-1:0]    r_cc, n_cc;
    logic [dof_pkg::AP_W-1:0]    r_av, n_av;
    logic [dof_pkg::AP_W-1:0]    r_avmin, n_avmin;
    logic [dof_pkg::FL_W-1:0]    r_fl, n_fl;
    logic [FD_W-1:0]             r_focus, n_focus;
    logic [SQ_W-1:0]             r_sq, n_sq;
    logic [DEN_W-1:0]            r_den, n_den;
    logic signed [HYP_W-1:0]     r_hyp, n_hyp;
    logic [M_W-1:0]              r_m, n_m;
    logic signed [NEAR_W-1:0]    r_near, n_near;
    logic signed [FAR_W-1:0]     r_far, n_far;
    logic [SUBJ_W-1:0]           r_subj, n_subj;
    logic                        r_dep_en, n_dep_en;

    logic                        r_out_valid;
    logic [OUT_W-1:0]            r_out_hyp;
    logic [NEAR_W-1:0]           r_out_near;
    logic [OUT_W-1:0]            r_out_far;
    logic [OUT_W-1:0]            r_out_depth;
    logic [SUBJ_W-1:0]           r_out_subj;

    logic                    w_idle;
    logic                    w_accept;
    logic                    w_known;
    logic                    w_op_state;
    logic                    w_skip;
    logic                    w_launch;
    logic                    w_done;
    logic                    w_load_out;
    logic                    w_focus_ok;
    logic                    w_subj_ok;
    logic [FD_W-1:0]         w_subj16;
    logic signed [HYP_W-1:0] w_focus_s;
    logic signed [HYP_W-1:0] w_subj_s;
    logic                    w_hyp_pos;
    logic                    w_hyp_gt_focus;
    logic                    w_hyp_gt_subj;
    logic signed [HYP_W-1:0] w_diff_focus;
    logic signed [HYP_W-1:0] w_diff_subj;
    logic signed [HYP_W-1:0] w_sum_subj;
    logic [W-1:0]            w_sq_sh;
    logic [W-1:0]            w_m_sh;
    logic signed [W-1:0]     w_depth;

    // Clamp a signed value to the top of the 32-bit signed range.
    function automatic logic [OUT_W-1:0] sat_out(input logic signed [W-1:0] x);
        logic [OUT_W-1:0] y;
        if (!x[W-1] && (|x[W-2:OUT_W-1])) begin
            y = {1'b0, {(OUT_W-1){1'b1}}};
        end else begin
            y = x[OUT_W-1:0];
        end
        return y;
    endfunction

    // Range checks and the small add/subtract terms around the divisions.
    assign w_idle         = (r_state == dof_pkg::S_IDLE);
    assign w_accept       = w_idle && i_req.valid;
    assign w_known        = (i_req.aperture != '0) && (i_req.focal_length != '0);
    assign w_done         = i_arsp.done;
    assign w_focus_ok     = (r_focus != '0) && (r_focus < FD_W'(dof_pkg::DIST_INF));
    assign w_subj_ok      = (r_subj != '0) && (r_subj < SUBJ_W'(dof_pkg::DIST_INF));
    assign w_subj16       = r_subj[FD_W-1:0];
    assign w_focus_s      = $signed(HYP_W'(r_focus));
    assign w_subj_s       = $signed(HYP_W'(w_subj16));
    assign w_hyp_pos      = (r_hyp > $signed(HYP_W'(0)));
    assign w_hyp_gt_focus = (r_hyp > w_focus_s);
    assign w_hyp_gt_subj  = (r_hyp > w_subj_s);
    assign w_diff_focus   = r_hyp - w_focus_s;
    assign w_diff_subj    = r_hyp - w_subj_s;
    assign w_sum_subj     = r_hyp + w_subj_s;
    assign w_sq_sh        = {r_sq, {(W-SQ_W){1'b0}}};
    assign w_m_sh         = {r_m, {(W-M_W){1'b0}}};
    assign w_depth        = W'(r_far) - W'(r_near);
    assign w_load_out     = (r_state == dof_pkg::S_FIN) && (!r_out_valid || o_res.ready);

    // A divisor of zero for either hyperfocal skips that step.
    always_comb begin
        case (r_state)
            dof_pkg::S_DMIN: w_skip = (r_avmin == '0) || (r_cc == '0);
            dof_pkg::S_DEN:  w_skip = (r_cc == '0);
            default:         w_skip = 1'b0;
        endcase
    end

    always_comb begin
        case (r_state)
            dof_pkg::S_SQ, dof_pkg::S_DMIN, dof_pkg::S_HMIN, dof_pkg::S_MSUB,
            dof_pkg::S_DSUB, dof_pkg::S_DEN, dof_pkg::S_HYP, dof_pkg::S_MM,
            dof_pkg::S_DNEAR, dof_pkg::S_DFAR: w_op_state = 1'b1;
            default:                           w_op_state = 1'b0;
        endcase
    end

    assign w_launch = w_op_state && !r_launched && !w_skip;

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            dof_pkg::S_IDLE: begin
                if (i_req.valid) begin
                    n_state = w_known ? dof_pkg::S_SQ : dof_pkg::S_FIN;
                end
            end
            dof_pkg::S_SQ: begin
                if (w_done) begin
                    n_state = r_mode ? dof_pkg::S_DMIN : dof_pkg::S_DEN;
                end
            end
            dof_pkg::S_DMIN: begin
                if (w_skip) begin
                    n_state = dof_pkg::S_DEN;
                end else if (w_done) begin
                    n_state = dof_pkg::S_HMIN;
                end
            end
            dof_pkg::S_HMIN: begin
                if (w_done) begin
                    n_state = dof_pkg::S_GUARD;
                end
            end
            dof_pkg::S_GUARD: begin
                n_state = (w_focus_ok && w_hyp_gt_focus) ? dof_pkg::S_MSUB : dof_pkg::S_DEN;
            end
            dof_pkg::S_MSUB: begin
                if (w_done) begin
                    n_state = dof_pkg::S_DSUB;
                end
            end
            dof_pkg::S_DSUB: begin
                if (w_done) begin
                    n_state = dof_pkg::S_DEN;
                end
            end
            dof_pkg::S_DEN: begin
                if (w_skip) begin
                    n_state = dof_pkg::S_CHK;
                end else if (w_done) begin
                    n_state = dof_pkg::S_HYP;
                end
            end
            dof_pkg::S_HYP: begin
                if (w_done) begin
                    n_state = dof_pkg::S_CHK;
                end
            end
            dof_pkg::S_CHK: begin
                if (w_subj_ok && (r_mode ? w_hyp_gt_subj : w_hyp_pos)) begin
                    n_state = dof_pkg::S_MM;
                end else begin
                    n_state = dof_pkg::S_FIN;
                end
            end
            dof_pkg::S_MM: begin
                if (w_done) begin
                    n_state = r_mode ? dof_pkg::S_DFAR : dof_pkg::S_DNEAR;
                end
            end
            dof_pkg::S_DNEAR: begin
                if (w_done) begin
                    n_state = w_hyp_gt_subj ? dof_pkg::S_DFAR : dof_pkg::S_FIN;
                end
            end
            dof_pkg::S_DFAR: begin
                if (w_done) begin
                    n_state = dof_pkg::S_FIN;
                end
            end
            dof_pkg::S_FIN: begin
                if (w_load_out) begin
                    n_state = dof_pkg::S_IDLE;
                end
            end
            default: n_state = dof_pkg::S_IDLE;
        endcase
    end

    // Operand selection for the shared unit.
    always_comb begin
        o_areq.start = w_launch;
        o_areq.op    = dof_pkg::OP_MUL;
        o_areq.a     = '0;
        o_areq.b     = '0;
        o_areq.steps = '0;
        case (r_state)
            dof_pkg::S_SQ: begin
                o_areq.a     = W'(r_fl);
                o_areq.b     = W'(r_fl);
                o_areq.steps = dof_pkg::CNT_W'(dof_pkg::FL_W);
            end
            dof_pkg::S_DMIN: begin
                o_areq.a     = W'(r_cc);
                o_areq.b     = W'(r_avmin);
                o_areq.steps = dof_pkg::CNT_W'(dof_pkg::AP_W);
            end
            dof_pkg::S_HMIN, dof_pkg::S_HYP: begin
                o_areq.op    = dof_pkg::OP_DIV;
                o_areq.a     = w_sq_sh;
                o_areq.b     = W'(r_den);
                o_areq.steps = dof_pkg::CNT_W'(SQ_W);
            end
            dof_pkg::S_MSUB: begin
                o_areq.a     = W'(r_hyp[HYP_W-2:0]);
                o_areq.b     = W'(r_focus);
                o_areq.steps = dof_pkg::CNT_W'(FD_W);
            end
            dof_pkg::S_DSUB: begin
                o_areq.op    = dof_pkg::OP_DIV;
                o_areq.a     = w_m_sh;
                o_areq.b     = W'(w_diff_focus[HYP_W-1:0]);
                o_areq.steps = dof_pkg::CNT_W'(M_W);
            end
            dof_pkg::S_DEN: begin
                o_areq.a     = W'(r_cc);
                o_areq.b     = W'(r_av);
                o_areq.steps = dof_pkg::CNT_W'(dof_pkg::AP_W);
            end
            dof_pkg::S_MM: begin
                o_areq.a     = W'(r_hyp[HYP_W-2:0]);
                o_areq.b     = W'(w_subj16);
                o_areq.steps = dof_pkg::CNT_W'(FD_W);
            end
            dof_pkg::S_DNEAR: begin
                o_areq.op    = dof_pkg::OP_DIV;
                o_areq.a     = w_m_sh;
                o_areq.b     = W'(w_sum_subj[HYP_W-1:0]);
                o_areq.steps = dof_pkg::CNT_W'(M_W);
            end
            dof_pkg::S_DFAR: begin
                o_areq.op    = dof_pkg::OP_DIV;
                o_areq.a     = w_m_sh;
                o_areq.b     = W'(w_diff_subj[HYP_W-1:0]);
                o_areq.steps = dof_pkg::CNT_W'(M_W);
            end
            default: ;
        endcase
    end

    // Handshake and result outputs.
    always_comb begin
        i_req.ready       = w_idle;
        o_res.valid       = r_out_valid;
        o_res.hyperfocal  = r_out_hyp;
        o_res.near_limit  = r_out_near;
        o_res.far_limit   = r_out_far;
        o_res.depth       = r_out_depth;
        o_res.subject_out = r_out_subj;
    end

    // Working registers: latch the request, then collect each result.
    always_comb begin
        n_launched = w_launch ? 1'b1 : (w_done ? 1'b0 : r_launched);
        n_mode     = r_mode;
        n_cc       = r_cc;
        n_av       = r_av;
        n_avmin    = r_avmin;
        n_fl       = r_fl;
        n_focus    = r_focus;
        n_sq       = r_sq;
        n_den      = r_den;
        n_hyp      = r_hyp;
        n_m        = r_m;
        n_near     = r_near;
        n_far      = r_far;
        n_subj     = r_subj;
        n_dep_en   = r_dep_en;
        case (r_state)
            dof_pkg::S_IDLE: begin
                if (w_accept) begin
                    n_mode   = i_cfg.subject_is_near_limit;
                    n_cc     = {1'b0, i_cfg.coc_size, 3'b000}
                             + {3'b000, i_cfg.coc_size, 1'b0};
                    n_av     = i_req.aperture;
                    n_avmin  = i_req.min_aperture;
                    n_fl     = i_req.focal_length;
                    n_focus  = i_req.focus_distance;
                    n_hyp    = '1;
                    n_far    = '1;
                    n_near   = '1;
                    n_dep_en = 1'b0;
                    if (w_known) begin
                        if (i_cfg.subject_is_near_limit) begin
                            n_near = $signed(NEAR_W'(i_req.focus_distance));
                        end else begin
                            n_subj = SUBJ_W'(i_req.focus_distance);
                        end
                    end
                end
            end
            dof_pkg::S_SQ: begin
                if (w_done) begin
                    n_sq = i_arsp.result[SQ_W-1:0];
                end
            end
            dof_pkg::S_DMIN, dof_pkg::S_DEN: begin
                if (w_skip) begin
                    n_hyp = '1;
                end else if (w_done) begin
                    n_den = i_arsp.result[DEN_W-1:0];
                end
            end
            dof_pkg::S_HMIN, dof_pkg::S_HYP: begin
                if (w_done) begin
                    n_hyp = $signed({1'b0, i_arsp.result[HYP_W-2:0]});
                end
            end
            dof_pkg::S_MSUB, dof_pkg::S_MM: begin
                if (w_done) begin
                    n_m = i_arsp.result[M_W-1:0];
                end
            end
            dof_pkg::S_DSUB: begin
                // The derived subject distance saturates before it is kept.
                if (w_done) begin
                    if (|i_arsp.result[M_W-1:SUBJ_W]) begin
                        n_subj = '1;
                    end else begin
                        n_subj = i_arsp.result[SUBJ_W-1:0];
                    end
                end
            end
            dof_pkg::S_CHK: begin
                n_dep_en = w_subj_ok;
            end
            dof_pkg::S_DNEAR: begin
                if (w_done) begin
                    n_near = $signed({1'b0, i_arsp.result[NEAR_W-2:0]});
                end
            end
            dof_pkg::S_DFAR: begin
                if (w_done) begin
                    n_far = $signed({1'b0, i_arsp.result[FAR_W-2:0]});
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= dof_pkg::S_IDLE;
            r_launched  <= 1'b0;
            r_subj      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_launched <= n_launched;
            r_subj     <= n_subj;
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
        r_mode   <= n_mode;
        r_cc     <= n_cc;
        r_av     <= n_av;
        r_avmin  <= n_avmin;
        r_fl     <= n_fl;
        r_focus  <= n_focus;
        r_sq     <= n_sq;
        r_den    <= n_den;
        r_hyp    <= n_hyp;
        r_m      <= n_m;
        r_near   <= n_near;
        r_far    <= n_far;
        r_dep_en <= n_dep_en;
        // The output register frees the sequencer for the next item.
        if (w_load_out) begin
            r_out_hyp   <= sat_out(W'(r_hyp));
            r_out_near  <= r_near;
            r_out_far   <= sat_out(W'(r_far));
            r_out_depth <= r_dep_en ? sat_out(w_depth) : '1;
            r_out_subj  <= r_subj;
        end
    end

    `DOF_ASSERT_IMPLIES(a_start_when_free, i_clk, i_rst_n, o_areq.start, !i_arsp.busy, "arith unit started while busy")
    `DOF_ASSERT_IMPLIES(a_subject_nonzero, i_clk, i_rst_n, (r_state == dof_pkg::S_DSUB) && w_done, i_arsp.result != '0, "derived subject distance is zero")
    `DOF_ASSERT_IMPLIES(a_near_below_subj, i_clk, i_rst_n, (r_state == dof_pkg::S_DNEAR) && w_done, i_arsp.result < W'(w_subj16), "near limit not below subject distance")
    `DOF_ASSERT_NEXT(a_fin_delivers, i_clk, i_rst_n, w_load_out, r_out_valid && (r_state == dof_pkg::S_IDLE), "result not loaded into output register")

endmodule

// ===== hw/rtl/depth_of_field_calculator_unit.sv =====
// One item at a time: the next item is taken as soon as the previous result sits in
// the output register. The shared shift-add multiply / restoring divide unit handles
// one bit per cycle; an item with an unknown aperture or focal length skips it.
// Reset (synchronous, active low): coc_size 5, normal mode, stored subject 0.
module depth_of_field_calculator_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    dof_req_if.sink                     i_req,
    dof_res_if.source                   o_res,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [dof_pkg::APB_AW-1:0]  paddr,
    input  logic [dof_pkg::APB_DW-1:0]  pwdata,
    output logic [dof_pkg::APB_DW-1:0]  prdata,
    output logic                        pready
);

    dof_pkg::t_cfg       w_cfg;
    dof_pkg::t_arith_req w_areq;
    dof_pkg::t_arith_rsp w_arsp;

    // Configuration registers.
    dof_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // Sequencer with working registers and the output register.
    dof_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (w_cfg),
        .i_req   (i_req),
        .o_res   (o_res),
        .o_areq  (w_areq),
        .i_arsp  (w_arsp)
    );

    // Shared iterative multiply/divide unit.
    dof_arith u_arith (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_areq),
        .o_rsp   (w_arsp)
    );

endmodule
